### rtl/ust_pkg.sv
// shared types and constants for the 8n1 uart transceiver core
// no dependencies; used by every module of the core by scoped names

package ust_pkg;

   // bit phase codes: 0..7 data bit, then stop, idle and start
   localparam logic [3:0] PH_STOPBIT  = 4'd8;
   localparam logic [3:0] PH_IDLE     = 4'd9;
   localparam logic [3:0] PH_STARTBIT = 4'd10;

   localparam logic [15:0] BIT_TICKS_RESET = 16'd16;
   localparam logic [15:0] TICK_COUNT_MAX  = 16'hFFFF;

   localparam int QUEUE_DEPTH_DEFAULT = 16;

   // entries in each decoupling queue
   localparam int STAGE_DEPTH = 2;

   // one tick of input: receive line level plus an optional transmit push
   typedef struct packed {
      logic       line_in;
      logic       push_valid;
      logic [7:0] push_byte;
   } req_item_type;

   // one tick of output
   typedef struct packed {
      logic       line_out;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       rx_frame_error;
      logic       tx_busy;
      logic       push_dropped;
   } rsp_item_type;

endpackage

### rtl/ust_fifo.sv
// small decoupling queue used in front of and behind the uart engine
// depends on ust_pkg for the queue depth

module ust_fifo #(
   parameter int WIDTH = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PW = (ust_pkg::STAGE_DEPTH > 1) ? $clog2(ust_pkg::STAGE_DEPTH) : 1;
   localparam int CW = $clog2(ust_pkg::STAGE_DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(ust_pkg::STAGE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(ust_pkg::STAGE_DEPTH);

   logic [WIDTH-1:0] slot_ff [ust_pkg::STAGE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == FULL_COUNT);
   assign empty   = (count_ff == '0);
   assign rd_data = slot_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### rtl/ust_engine.sv
// uart engine: one tick of transmitter, receiver and transmit queue per step
// depends on ust_pkg for phase codes and item types

module ust_engine #(
   parameter int QUEUE_DEPTH = ust_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [15:0]           bit_ticks,
   input  logic                  step,
   input  ust_pkg::req_item_type req_item,
   output ust_pkg::rsp_item_type rsp_item
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
   localparam logic [FW-1:0] FULL_FILL = FW'(QUEUE_DEPTH);

   logic [7:0]    queue_mem [QUEUE_DEPTH];
   logic [7:0]    tx_data_ff;

   logic [3:0]    tx_phase_ff, tx_phase_in;
   logic [15:0]   tx_count_ff, tx_count_in;
   logic [3:0]    rx_phase_ff, rx_phase_in;
   logic [15:0]   rx_count_ff, rx_count_in;
   logic [7:0]    rx_shift_ff, rx_shift_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [FW-1:0] fill_ff, fill_in, fill_mid;

   logic          tx_boundary, rx_boundary, rx_half;
   logic          line_out, rx_good, rx_bad, dropped, queue_wr;

   // transmitter tick
   always_comb begin
      tx_boundary = (tx_count_ff >= bit_ticks);
      tx_phase_in = tx_phase_ff;
      tx_count_in = (tx_count_ff == ust_pkg::TICK_COUNT_MAX) ? tx_count_ff
                                                              : tx_count_ff + 16'd1;
      head_in     = head_ff;
      fill_mid    = fill_ff;
      line_out    = 1'b1;
      if (tx_phase_ff == ust_pkg::PH_STARTBIT) begin
         line_out = 1'b0;
         if (tx_boundary) begin
            tx_phase_in = 4'd0;
            tx_count_in = '0;
         end
      end else if (tx_phase_ff < ust_pkg::PH_STOPBIT) begin
         line_out = tx_data_ff[tx_phase_ff[2:0]];
         if (tx_boundary) begin
            tx_phase_in = tx_phase_ff + 4'd1;
            tx_count_in = '0;
         end
      end else if (tx_phase_ff == ust_pkg::PH_STOPBIT) begin
         if (tx_boundary) begin
            tx_phase_in = ust_pkg::PH_IDLE;
            tx_count_in = '0;
            if (fill_ff != '0) begin
               fill_mid = fill_ff - 1'b1;
               head_in  = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
            end
         end
      end else begin
         tx_phase_in = ust_pkg::PH_IDLE;
         if (fill_ff != '0) begin
            tx_phase_in = ust_pkg::PH_STARTBIT;
            tx_count_in = '0;
         end
      end
   end

   // receiver tick
   always_comb begin
      rx_boundary = (rx_count_ff >= bit_ticks);
      rx_half     = (rx_count_ff >= {1'b0, bit_ticks[15:1]});
      rx_phase_in = rx_phase_ff;
      rx_count_in = (rx_count_ff == ust_pkg::TICK_COUNT_MAX) ? rx_count_ff
                                                              : rx_count_ff + 16'd1;
      rx_shift_in = rx_shift_ff;
      rx_good     = 1'b0;
      rx_bad      = 1'b0;
      if (rx_phase_ff == ust_pkg::PH_STARTBIT) begin
         if (rx_half && !req_item.line_in) begin
            rx_shift_in = '0;
            rx_count_in = '0;
            rx_phase_in = 4'd0;
         end
      end else if (rx_phase_ff < ust_pkg::PH_STOPBIT) begin
         if (rx_boundary) begin
            rx_shift_in = {req_item.line_in, rx_shift_ff[7:1]};
            rx_count_in = '0;
            rx_phase_in = rx_phase_ff + 4'd1;
         end
      end else if (rx_phase_ff == ust_pkg::PH_STOPBIT) begin
         if (rx_boundary) begin
            rx_count_in = '0;
            rx_phase_in = ust_pkg::PH_IDLE;
            rx_good     = req_item.line_in;
            rx_bad      = !req_item.line_in;
         end
      end else begin
         rx_phase_in = ust_pkg::PH_IDLE;
         if (!req_item.line_in) begin
            rx_count_in = '0;
            rx_phase_in = ust_pkg::PH_STARTBIT;
         end
      end
   end

   // queue push, applied after the transmitter may have popped
   always_comb begin
      tail_in  = tail_ff;
      fill_in  = fill_mid;
      dropped  = 1'b0;
      queue_wr = 1'b0;
      if (req_item.push_valid) begin
         if (fill_mid == FULL_FILL) begin
            dropped = 1'b1;
         end else begin
            queue_wr = 1'b1;
            tail_in  = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
            fill_in  = fill_mid + 1'b1;
         end
      end
   end

   // result assembly
   always_comb begin
      rsp_item.line_out       = line_out;
      rsp_item.rx_valid       = rx_good;
      rsp_item.rx_byte        = rx_good ? rx_shift_ff : 8'd0;
      rsp_item.rx_frame_error = rx_bad;
      rsp_item.tx_busy        = (tx_phase_in != ust_pkg::PH_IDLE) || (fill_in != '0);
      rsp_item.push_dropped   = dropped;
   end

   // state registers, advanced once per step
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_phase_ff <= ust_pkg::PH_IDLE;
         tx_count_ff <= '0;
         rx_phase_ff <= ust_pkg::PH_IDLE;
         rx_count_ff <= '0;
         rx_shift_ff <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         fill_ff     <= '0;
      end else if (step) begin
         tx_phase_ff <= tx_phase_in;
         tx_count_ff <= tx_count_in;
         rx_phase_ff <= rx_phase_in;
         rx_count_ff <= rx_count_in;
         rx_shift_ff <= rx_shift_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         fill_ff     <= fill_in;
      end
   end

   // transmit queue memory, head byte read into a register every cycle
   always_ff @(posedge clock) begin
      if (step && queue_wr) begin
         queue_mem[tail_ff] <= req_item.push_byte;
      end
      tx_data_ff <= queue_mem[head_ff];
   end

endmodule

### rtl/uart_serial_transceiver_core.sv
// top level of the 8n1 uart transceiver core: input queue, engine, result queue
// depends on ust_pkg, ust_fifo and ust_engine
//
//   channel   direction  handshake             payload
//   req       in         push / full           req_line_in, req_push_valid, req_push_byte
//   rsp       out        empty / pop           rsp_line_out, rsp_rx_*, rsp_tx_busy,
//                                              rsp_push_dropped
//   csr       in         csr_valid / csr_ready csr_bit_ticks
//
// one tick item per cycle sustained while results are popped; an item is registered in
// the input queue, then in the result queue: the engine steps on the input queue head.
// synchronous active-high reset empties both queues and idles receiver and transmitter.
// a stall on the result side fills the result queue and then the input queue, after
// which full rises; the engine only steps when both queues allow it.
// csr writes are always accepted and take effect for the next engine step.

module uart_serial_transceiver_core #(
   parameter int QUEUE_DEPTH = ust_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_line_in,
   input  logic        req_push_valid,
   input  logic [7:0]  req_push_byte,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_line_out,
   output logic        rsp_rx_valid,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_rx_frame_error,
   output logic        rsp_tx_busy,
   output logic        rsp_push_dropped,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_bit_ticks
);

   localparam int REQ_W = $bits(ust_pkg::req_item_type);
   localparam int RSP_W = $bits(ust_pkg::rsp_item_type);

   logic [15:0]           bit_ticks_ff;
   ust_pkg::req_item_type req_in_item, req_head;
   ust_pkg::rsp_item_type rsp_new, rsp_head;
   logic                  req_empty, rsp_full, step;

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ticks_ff <= ust_pkg::BIT_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         bit_ticks_ff <= csr_bit_ticks;
      end
   end

   // front: input queue
   always_comb begin
      req_in_item.line_in    = req_line_in;
      req_in_item.push_valid = req_push_valid;
      req_in_item.push_byte  = req_push_byte;
   end

   ust_fifo #(.WIDTH(REQ_W)) u_req_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (req_in_item),
      .full    (full),
      .rd_en   (step),
      .rd_data (req_head),
      .empty   (req_empty)
   );

   // engine steps when a tick waits and the result queue has room
   assign step = !req_empty && !rsp_full;

   ust_engine #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .bit_ticks (bit_ticks_ff),
      .step      (step),
      .req_item  (req_head),
      .rsp_item  (rsp_new)
   );

   // back: result queue
   ust_fifo #(.WIDTH(RSP_W)) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (step),
      .wr_data (rsp_new),
      .full    (rsp_full),
      .rd_en   (pop),
      .rd_data (rsp_head),
      .empty   (empty)
   );

   assign rsp_line_out       = rsp_head.line_out;
   assign rsp_rx_valid       = rsp_head.rx_valid;
   assign rsp_rx_byte        = rsp_head.rx_byte;
   assign rsp_rx_frame_error = rsp_head.rx_frame_error;
   assign rsp_tx_busy        = rsp_head.tx_busy;
   assign rsp_push_dropped   = rsp_head.push_dropped;

endmodule

### rtl/ust_checker.sv
// port-level checks for the uart transceiver core, bound to the top level
// depends on uart_serial_transceiver_core port names only

module ust_checker (
   input logic       clock,
   input logic       reset,
   input logic       empty,
   input logic       pop,
   input logic       rsp_line_out,
   input logic       rsp_rx_valid,
   input logic [7:0] rsp_rx_byte,
   input logic       rsp_rx_frame_error,
   input logic       rsp_tx_busy,
   input logic       rsp_push_dropped
);

   // no result is waiting right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> empty)
      else $error("result waiting right after reset");

   // a frame is either a good byte or a framing error, never both
   a_rx_exclusive: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_rx_valid && rsp_rx_frame_error))
      else $error("good byte and framing error in one result");

   // received byte reads zero unless a byte completed
   a_rx_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_rx_valid) |-> (rsp_rx_byte == 8'd0))
      else $error("received byte nonzero without a completed byte");

   // a waiting result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_rx_byte) && $stable(rsp_line_out)
                           && $stable(rsp_tx_busy) && $stable(rsp_push_dropped)))
      else $error("waiting result changed before transfer");

endmodule

bind uart_serial_transceiver_core ust_checker u_ust_checker (
   .clock              (clock),
   .reset              (reset),
   .empty              (empty),
   .pop                (pop),
   .rsp_line_out       (rsp_line_out),
   .rsp_rx_valid       (rsp_rx_valid),
   .rsp_rx_byte        (rsp_rx_byte),
   .rsp_rx_frame_error (rsp_rx_frame_error),
   .rsp_tx_busy        (rsp_tx_busy),
   .rsp_push_dropped   (rsp_push_dropped)
);
